// File: hw/rtl/adv_rtt_pkg.sv
package adv_rtt_pkg;

    localparam int ID_BYTES_DEF = 6;
    localparam int ID_BYTES_MAX = 8;

    localparam int IDENT_W = 48;
    localparam int THRESH_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IDENTIFIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENTIFIER_READY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THRESHOLD = 2'd2;

    localparam logic [7:0] AD_TYPE_MANUF = 8'hFF;
    localparam logic signed [THRESH_W-1:0] THRESH_RESET = 16'sd250;

    localparam logic [1:0] PH_LEN = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [3:0] PIDX_MAX = 4'd15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_report;
    } item_t;

    typedef struct packed {
        logic                       valve_level;
        logic                       updated;
        logic signed [THRESH_W-1:0] temperature;
    } result_t;

endpackage

// File: hw/rtl/adv_record_temp_threshold_top.sv
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    item_t   (data_byte, last_in_report)
// result    out        result_valid / result_stall result_t (valve_level, updated, temperature)
// config    in         cfg_write                  cfg_index, cfg_data
//
// One request per cycle unless stalled; a result appears the cycle after its request is taken.
// The parser state is updated and the result register loaded in the same cycle.
// item_stall follows result_stall while a result is held in the output register.
// Reset: parser expects a length byte, level low, threshold 250, identifier not ready.
module adv_record_temp_threshold_top
    import adv_rtt_pkg::*;
#(
    parameter int ID_BYTES = ID_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IDENT_W-1:0]   cfg_data
);

    localparam logic [7:0] MIN_LEN = 8'(ID_BYTES + 3);
    localparam logic [3:0] IDX_LO = 4'(ID_BYTES);
    localparam logic [3:0] IDX_HI = 4'(ID_BYTES + 1);

    logic [IDENT_W-1:0]         ident_reg;
    logic                       ready_reg;
    logic signed [THRESH_W-1:0] thresh_reg;

    logic [1:0]                 phase_reg, phase_next;
    logic [7:0]                 left_reg, left_next;
    logic [3:0]                 pidx_reg, pidx_next;
    logic                       cand_reg, cand_next;
    logic                       match_reg, match_next;
    logic [7:0]                 tlow_reg, tlow_next;
    logic signed [THRESH_W-1:0] temp_reg, temp_next;
    logic                       level_reg, level_next;
    logic                       upd;

    logic                       result_valid_reg;
    result_t                    result_reg;

    logic                       accept;
    logic [8*ID_BYTES_MAX-1:0]  ident_ext;
    logic [7:0]                 id_byte;
    logic [7:0]                 left_dec;
    logic signed [THRESH_W-1:0] temp_cand;

    assign item_stall = result_valid_reg && result_stall;
    assign accept = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    assign ident_ext = {{(8*ID_BYTES_MAX-IDENT_W){1'b0}}, ident_reg};
    assign id_byte = ident_ext[pidx_reg[2:0]*8 +: 8];
    assign left_dec = left_reg - 8'd1;
    assign temp_cand = {item.data_byte, tlow_reg};

    always_comb
    begin
        phase_next = phase_reg;
        left_next = left_reg;
        pidx_next = pidx_reg;
        cand_next = cand_reg;
        match_next = match_reg;
        tlow_next = tlow_reg;
        temp_next = temp_reg;
        level_next = level_reg;
        upd = 1'b0;
        unique case (phase_reg)
            PH_TYPE:
            begin
                cand_next = (item.data_byte == AD_TYPE_MANUF) && (left_reg >= MIN_LEN);
                match_next = 1'b1;
                pidx_next = '0;
                left_next = left_dec;
                phase_next = (left_dec == 8'd0) ? PH_LEN : PH_BODY;
            end
            PH_BODY:
            begin
                if (cand_reg)
                begin
                    if (pidx_reg < IDX_LO)
                    begin
                        if (item.data_byte != id_byte)
                        begin
                            match_next = 1'b0;
                        end
                    end
                    else if (pidx_reg == IDX_LO)
                    begin
                        tlow_next = item.data_byte;
                    end
                    else if (pidx_reg == IDX_HI)
                    begin
                        if (match_reg && ready_reg)
                        begin
                            temp_next = temp_cand;
                            level_next = (temp_cand >= thresh_reg);
                            upd = 1'b1;
                        end
                    end
                    if (pidx_reg < PIDX_MAX)
                    begin
                        pidx_next = pidx_reg + 4'd1;
                    end
                end
                left_next = left_dec;
                if (left_dec == 8'd0)
                begin
                    phase_next = PH_LEN;
                end
            end
            default:
            begin
                if (item.data_byte != 8'd0)
                begin
                    left_next = item.data_byte;
                    phase_next = PH_TYPE;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
        endcase
        if (item.last_in_report)
        begin
            phase_next = PH_LEN;
            left_next = '0;
            cand_next = 1'b0;
            match_next = 1'b0;
            pidx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg <= '0;
            ready_reg <= 1'b0;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OWN_IDENTIFIER:   ident_reg <= cfg_data;
                CFG_IDENTIFIER_READY: ready_reg <= cfg_data[0];
                CFG_TEMP_THRESHOLD:   thresh_reg <= cfg_data[THRESH_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            left_reg <= '0;
            pidx_reg <= '0;
            cand_reg <= 1'b0;
            match_reg <= 1'b0;
            tlow_reg <= '0;
            temp_reg <= '0;
            level_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg <= left_next;
            pidx_reg <= pidx_next;
            cand_reg <= cand_next;
            match_reg <= match_next;
            tlow_reg <= tlow_next;
            temp_reg <= temp_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg.valve_level <= level_next;
            result_reg.updated <= upd;
            result_reg.temperature <= temp_next;
        end
    end

`ifndef SYNTH
    // level rewritten from the temperature of the same request
    a_upd_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.updated
        |-> result.valve_level == (result.temperature >= thresh_reg))
        else $error("updated result level disagrees with threshold");

    // end of report returns the parser to a length byte
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last_in_report |=> phase_reg == PH_LEN && left_reg == 8'd0)
        else $error("parser not reset after last byte of report");

    // body phase always has bytes left
    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> left_reg != 8'd0)
        else $error("body phase with no bytes left");

    // input only held off by a waiting result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid_reg)
        else $error("input stalled without a pending result");
`endif

endmodule
